FILE: rtl/rmvs_pkg.sv
// Shared types and constants for the running mean / variance statistics block.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package rmvs_pkg;

	// Fixed-point formats: samples, min, max and mean are signed Q(SAMPLE_BITS-FRACTION_BITS).FRACTION_BITS
	localparam int SAMPLE_BITS   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int COUNT_BITS    = 32;
	localparam int SPREAD_BITS   = 64;

	// Derived widths
	localparam int DIFF_BITS     = SAMPLE_BITS + 1;              // x - mean, signed
	localparam int PROD_BITS     = 2 * DIFF_BITS;                // |d_old| * |d_new|
	localparam int RAD_BITS      = SPREAD_BITS + FRACTION_BITS;  // variance << FRACTION_BITS
	localparam int ROOT_BITS     = (RAD_BITS + 1) / 2;
	localparam int DIV_STEP_BITS = $clog2(SPREAD_BITS + 1);

	// Request type codes
	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [SAMPLE_BITS-1:0]        STDDEV_MAX = '1;

	// Input request
	typedef struct packed {
		logic                          req_type;
		logic signed [SAMPLE_BITS-1:0] sample;
	} in_t;

	// Result
	typedef struct packed {
		logic [COUNT_BITS-1:0]         sample_total;
		logic signed [SAMPLE_BITS-1:0] min_value;
		logic signed [SAMPLE_BITS-1:0] max_value;
		logic signed [SAMPLE_BITS-1:0] mean_value;
		logic [SAMPLE_BITS-1:0]        stddev_value;
		logic                          count_saturated;
		logic                          spread_saturated;
	} out_t;

	// Decoded request held in the front queue
	typedef struct packed {
		logic                          clear;
		logic signed [SAMPLE_BITS-1:0] sample;
	} cmd_t;

	// Serial divider control
	typedef struct packed {
		logic                     start;
		logic [SPREAD_BITS-1:0]   dividend;
		logic [COUNT_BITS-1:0]    divisor;
		logic [DIV_STEP_BITS-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [SPREAD_BITS-1:0] quotient;
	} div_rsp_t;

	// Serial square root control
	typedef struct packed {
		logic                start;
		logic [RAD_BITS-1:0] radicand;
	} root_req_t;

	typedef struct packed {
		logic                 done;
		logic [ROOT_BITS-1:0] root;
	} root_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/rmvs_front.sv
// Front end: accepts requests, decodes clear vs. add, and queues them for the back end.
// Depends on rmvs_pkg.
`default_nettype none

module rmvs_front
	import rmvs_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire in_t  req,
	output logic      cmd_valid,
	input  wire logic cmd_ready,
	output cmd_t      cmd
);

	localparam int PTR_BITS  = $clog2(DEPTH);
	localparam int FILL_BITS = $clog2(DEPTH + 1);

	cmd_t                 slot_q [DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [FILL_BITS-1:0] fill_q;
	logic                 push;
	logic                 pop;
	cmd_t                 decoded;

	// Classify the incoming request
	always_comb begin
		decoded.clear  = (req.req_type == REQ_CLEAR);
		decoded.sample = req.sample;
	end

	assign req_ready = (fill_q != FILL_BITS'(DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = slot_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = cmd_valid && cmd_ready;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= decoded;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rmvs_div.sv
// Restoring serial divider, one quotient bit per cycle, shared by the mean and variance steps.
// Depends on rmvs_pkg.
`default_nettype none

module rmvs_div
	import rmvs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t div_req,
	output div_rsp_t      div_rsp
);

	logic                     busy_q;
	logic                     done_q;
	logic [DIV_STEP_BITS-1:0] left_q;
	logic [COUNT_BITS-1:0]    rem_q;
	logic [COUNT_BITS-1:0]    dsr_q;
	logic [SPREAD_BITS-1:0]   dvd_q;
	logic [SPREAD_BITS-1:0]   quo_q;
	logic [COUNT_BITS:0]      shifted;
	logic [COUNT_BITS:0]      trial;
	logic                     fits;

	// One restoring step
	always_comb begin
		shifted = {rem_q, dvd_q[SPREAD_BITS-1]};
		trial   = shifted - {1'b0, dsr_q};
		fits    = (shifted >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (div_req.start) begin
				busy_q <= 1'b1;
				left_q <= div_req.steps;
				rem_q  <= '0;
				dsr_q  <= div_req.divisor;
				dvd_q  <= div_req.dividend;
				quo_q  <= '0;
			end else if (busy_q) begin
				rem_q  <= fits ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
				quo_q  <= {quo_q[SPREAD_BITS-2:0], fits};
				dvd_q  <= {dvd_q[SPREAD_BITS-2:0], 1'b0};
				left_q <= left_q - 1'b1;
				if (left_q == DIV_STEP_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign div_rsp.done     = done_q;
	assign div_rsp.quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/rmvs_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle (floor of the exact root).
// Depends on rmvs_pkg.
`default_nettype none

module rmvs_sqrt
	import rmvs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire root_req_t root_req,
	output root_rsp_t      root_rsp
);

	localparam int PAD_BITS  = 2 * ROOT_BITS;
	localparam int LEFT_BITS = $clog2(ROOT_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [LEFT_BITS-1:0] left_q;
	logic [PAD_BITS-1:0]  rad_q;
	logic [ROOT_BITS:0]   rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [ROOT_BITS+2:0] shifted;
	logic [ROOT_BITS+2:0] trial;
	logic [ROOT_BITS+2:0] diff;
	logic                 fits;

	// Bring down two radicand bits and try the next root bit
	always_comb begin
		shifted = {rem_q, rad_q[PAD_BITS-1:PAD_BITS-2]};
		trial   = {1'b0, root_q, 2'b01};
		diff    = shifted - trial;
		fits    = (shifted >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (root_req.start) begin
				busy_q <= 1'b1;
				left_q <= LEFT_BITS'(ROOT_BITS);
				rad_q  <= PAD_BITS'(root_req.radicand);
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rem_q  <= fits ? diff[ROOT_BITS:0] : shifted[ROOT_BITS:0];
				root_q <= {root_q[ROOT_BITS-2:0], fits};
				rad_q  <= {rad_q[PAD_BITS-3:0], 2'b00};
				left_q <= left_q - 1'b1;
				if (left_q == LEFT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign root_rsp.done = done_q;
	assign root_rsp.root = root_q;

endmodule

`default_nettype wire

FILE: rtl/rmvs_back.sv
// Back end: sequences the Welford update, the serial multiply, and the variance/root steps;
// holds the statistics and the result register. Depends on rmvs_pkg.
`default_nettype none

module rmvs_back
	import rmvs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_ready,
	input  wire cmd_t      cmd,
	output div_req_t       div_req,
	input  wire div_rsp_t  div_rsp,
	output root_req_t      root_req,
	input  wire root_rsp_t root_rsp,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output out_t           rsp
);

	localparam int MUL_LEFT_BITS = $clog2(DIFF_BITS + 1);
	localparam int INC_BITS      = PROD_BITS + SPREAD_BITS;
	localparam int SAT_BITS      = ROOT_BITS + SAMPLE_BITS;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIFF,
		S_MEAN_GO,
		S_DIV_MEAN,
		S_PREP,
		S_MUL,
		S_ACC,
		S_DEV_GO,
		S_DIV_DEV,
		S_ROOT_GO,
		S_ROOT,
		S_FINISH
	} state_t;

	state_t                        state_q;
	logic [COUNT_BITS-1:0]         count_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SAMPLE_BITS-1:0] mean_q;
	logic [SPREAD_BITS-1:0]        spread_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [DIFF_BITS-1:0]          mag_q;
	logic                          neg_q;
	logic [DIFF_BITS-1:0]          mul_hi_q;
	logic [DIFF_BITS-1:0]          mul_lo_q;
	logic [MUL_LEFT_BITS-1:0]      mul_left_q;
	logic [SAMPLE_BITS-1:0]        stddev_q;
	logic                          rsp_valid_q;
	out_t                          rsp_q;

	logic [DIFF_BITS-1:0]   x_ext;
	logic [DIFF_BITS-1:0]   mean_ext;
	logic [DIFF_BITS-1:0]   d_old;
	logic [DIFF_BITS-1:0]   quot;
	logic [DIFF_BITS-1:0]   mean_sum;
	logic [DIFF_BITS-1:0]   d_new_mag;
	logic [DIFF_BITS:0]     mul_sum;
	logic [INC_BITS-1:0]    inc_ext;
	logic                   inc_big;
	logic [SPREAD_BITS:0]   spread_sum;
	logic [SAT_BITS-1:0]    root_wide;
	logic [SAMPLE_BITS-1:0] stddev_sat;
	logic [COUNT_BITS-1:0]  count_inc;

	// Datapath between the sequencer states
	always_comb begin
		x_ext     = {x_q[SAMPLE_BITS-1], x_q};
		mean_ext  = {mean_q[SAMPLE_BITS-1], mean_q};
		d_old     = x_ext - mean_ext;
		// the mean moves toward the sample by the truncated quotient
		quot      = div_rsp.quotient[DIFF_BITS-1:0];
		mean_sum  = mean_ext + (neg_q ? ~quot : quot) + DIFF_BITS'(neg_q);
		// new deviation keeps the sign of the old one, or is zero
		d_new_mag = neg_q ? (mean_ext - x_ext) : (x_ext - mean_ext);
		// shift-add multiply, one multiplier bit per cycle
		mul_sum   = {1'b0, mul_hi_q} + (mul_lo_q[0] ? {1'b0, mag_q} : '0);
		inc_ext   = INC_BITS'({mul_hi_q, mul_lo_q}) >> FRACTION_BITS;
		inc_big   = |inc_ext[INC_BITS-1:SPREAD_BITS];
		spread_sum = {1'b0, spread_q} + {1'b0, inc_ext[SPREAD_BITS-1:0]};
		root_wide  = SAT_BITS'(root_rsp.root);
		stddev_sat = (root_wide > SAT_BITS'(STDDEV_MAX)) ? STDDEV_MAX
			: SAMPLE_BITS'(root_wide);
		count_inc  = (count_q == '1) ? count_q : count_q + 1'b1;
	end

	// Unit requests
	always_comb begin
		div_req.start    = (state_q == S_MEAN_GO) || (state_q == S_DEV_GO);
		div_req.dividend = spread_q;
		div_req.divisor  = count_q - 1'b1;
		div_req.steps    = DIV_STEP_BITS'(SPREAD_BITS);
		if (state_q == S_MEAN_GO) begin
			div_req.dividend = SPREAD_BITS'(mag_q) << (SPREAD_BITS - DIFF_BITS);
			div_req.divisor  = count_q;
			div_req.steps    = DIV_STEP_BITS'(DIFF_BITS);
		end
		root_req.start    = (state_q == S_ROOT_GO);
		root_req.radicand = RAD_BITS'(div_rsp.quotient) << FRACTION_BITS;
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Sequencer, statistics and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			min_q       <= SAMPLE_MAX;
			max_q       <= SAMPLE_MIN;
			mean_q      <= '0;
			spread_q    <= '0;
			x_q         <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			mul_hi_q    <= '0;
			mul_lo_q    <= '0;
			mul_left_q  <= '0;
			stddev_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// the finish state reloads the result register itself
			if (rsp_ready && state_q != S_FINISH) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						x_q <= cmd.sample;
						if (cmd.clear) begin
							count_q  <= '0;
							min_q    <= SAMPLE_MAX;
							max_q    <= SAMPLE_MIN;
							mean_q   <= '0;
							spread_q <= '0;
							stddev_q <= '0;
							state_q  <= S_FINISH;
						end else begin
							count_q <= count_inc;
							if (cmd.sample < min_q) begin
								min_q <= cmd.sample;
							end
							if (cmd.sample > max_q) begin
								max_q <= cmd.sample;
							end
							if (count_q == '0) begin
								// first sample sets the mean directly
								mean_q   <= cmd.sample;
								spread_q <= '0;
								stddev_q <= '0;
								state_q  <= S_FINISH;
							end else begin
								state_q <= S_DIFF;
							end
						end
					end
				end
				S_DIFF: begin
					neg_q   <= d_old[DIFF_BITS-1];
					mag_q   <= d_old[DIFF_BITS-1] ? (~d_old + 1'b1) : d_old;
					state_q <= S_MEAN_GO;
				end
				S_MEAN_GO: begin
					state_q <= S_DIV_MEAN;
				end
				S_DIV_MEAN: begin
					if (div_rsp.done) begin
						mean_q  <= mean_sum[SAMPLE_BITS-1:0];
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					mul_hi_q   <= '0;
					mul_lo_q   <= d_new_mag;
					mul_left_q <= MUL_LEFT_BITS'(DIFF_BITS);
					state_q    <= S_MUL;
				end
				S_MUL: begin
					mul_hi_q   <= mul_sum[DIFF_BITS:1];
					mul_lo_q   <= {mul_sum[0], mul_lo_q[DIFF_BITS-1:1]};
					mul_left_q <= mul_left_q - 1'b1;
					if (mul_left_q == MUL_LEFT_BITS'(1)) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					// saturating accumulate of the truncated increment
					spread_q <= (inc_big || spread_sum[SPREAD_BITS]) ? '1
						: spread_sum[SPREAD_BITS-1:0];
					state_q  <= S_DEV_GO;
				end
				S_DEV_GO: begin
					state_q <= S_DIV_DEV;
				end
				S_DIV_DEV: begin
					if (div_rsp.done) begin
						state_q <= S_ROOT_GO;
					end
				end
				S_ROOT_GO: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (root_rsp.done) begin
						stddev_q <= stddev_sat;
						state_q  <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q            <= 1'b1;
						rsp_q.sample_total     <= count_q;
						rsp_q.min_value        <= min_q;
						rsp_q.max_value        <= max_q;
						rsp_q.mean_value       <= mean_q;
						rsp_q.stddev_value     <= stddev_q;
						rsp_q.count_saturated  <= (count_q == '1);
						rsp_q.spread_saturated <= (spread_q == '1);
						state_q                <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// An accepted request always starts work
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> state_q != S_IDLE)
		else $error("accepted request did not leave idle");

	// Divider results only arrive while the sequencer waits for them
	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV_MEAN || state_q == S_DIV_DEV))
		else $error("divider finished outside a divide wait");

	a_root_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		root_rsp.done |-> state_q == S_ROOT)
		else $error("root unit finished outside the root wait");

	// Once any sample is in, the range is ordered
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> min_q <= max_q)
		else $error("minimum above maximum");

	// Deviation is zero below two samples
	a_stddev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.sample_total < COUNT_BITS'(2) |-> rsp_q.stddev_value == '0)
		else $error("nonzero deviation with fewer than two samples");
`endif

endmodule

`default_nettype wire

FILE: rtl/running_mean_variance_stats_top.sv
// Clear and the first sample go straight from idle to the result register; a later sample
// (signed Q16.16) first passes the mean divide, the multiply, the variance divide and the root.
// One request is processed at a time: the back end takes the next only after the last result is
// loaded; the serial divider (one quotient bit per cycle, used twice), the shift-add multiply and
// the one-bit-per-cycle root set how long a later sample takes.
// Reset (arst_n low, asynchronous) empties the queue and sets the statistics to the empty state.
`default_nettype none

module running_mean_variance_stats_top
	import rmvs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire in_t  req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output out_t      rsp
);

	logic      cmd_valid;
	logic      cmd_ready;
	cmd_t      cmd;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	root_req_t root_req;
	root_rsp_t root_rsp;

	rmvs_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	rmvs_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	rmvs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.root_req (root_req),
		.root_rsp (root_rsp)
	);

	rmvs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.root_req  (root_req),
		.root_rsp  (root_rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for running_mean_variance_stats_top: running count, min, max, mean, stddev.
// Predicts every result from its own copy of the statistics; needs rmvs_pkg and the top only.

module testbench;
	import rmvs_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int TAIL_CYCLES  = 250;

	// Expected-statistics tracker: mirrors the block's state, queues its results
	class stats_checker;
		logic [COUNT_BITS-1:0]         tally;
		logic signed [SAMPLE_BITS-1:0] low_mark;
		logic signed [SAMPLE_BITS-1:0] high_mark;
		logic signed [SAMPLE_BITS-1:0] mean_est;
		logic [SPREAD_BITS-1:0]        spread_sum;
		out_t                          expected_stats[$];
		int                            errors;

		function new();
			errors = 0;
			clear_stats();
		endfunction

		function void clear_stats();
			tally      = '0;
			low_mark   = SAMPLE_MAX;
			high_mark  = SAMPLE_MIN;
			mean_est   = '0;
			spread_sum = '0;
		endfunction

		// Welford update with truncating division and a saturating spread sum
		function void add_sample(logic signed [SAMPLE_BITS-1:0] x);
			longint                d_old, d_new, mean_next;
			longint unsigned       m_old, m_new, q;
			logic [127:0]          step;
			if (tally != '1)
				tally++;
			if (x < low_mark)
				low_mark = x;
			if (x > high_mark)
				high_mark = x;
			if (tally == 1) begin
				mean_est   = x;
				spread_sum = '0;
			end else begin
				d_old     = longint'(x) - longint'(mean_est);
				m_old     = (d_old < 0) ? -d_old : d_old;
				q         = m_old / tally;
				mean_next = (d_old < 0) ? longint'(mean_est) - longint'(q)
				                        : longint'(mean_est) + longint'(q);
				mean_est  = mean_next[SAMPLE_BITS-1:0];
				d_new     = longint'(x) - mean_next;
				m_new     = (d_new < 0) ? -d_new : d_new;
				step      = (128'(m_old) * 128'(m_new)) >> FRACTION_BITS;
				if (step[127:64] != 0 || step[63:0] > ~spread_sum)
					spread_sum = '1;
				else
					spread_sum = spread_sum + step[63:0];
			end
		endfunction

		// floor(sqrt((spread / (n-1)) << FRACTION_BITS)), saturated to the field
		function logic [SAMPLE_BITS-1:0] stddev();
			logic [SPREAD_BITS-1:0] var_q;
			logic [127:0]           rad;
			logic [63:0]            root, trial;
			if (tally < 2)
				return '0;
			var_q = spread_sum / (tally - 1);
			rad   = 128'(var_q) << FRACTION_BITS;
			root  = '0;
			for (int b = 63; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (128'(trial) * 128'(trial) <= rad)
					root = trial;
			end
			if (root > STDDEV_MAX)
				return STDDEV_MAX;
			return root[SAMPLE_BITS-1:0];
		endfunction

		// Accepted request: update the statistics and queue the result they imply
		function void take_request(in_t r);
			out_t e;
			if (r.req_type == REQ_CLEAR)
				clear_stats();
			else
				add_sample(r.sample);
			e.sample_total     = tally;
			e.min_value        = low_mark;
			e.max_value        = high_mark;
			e.mean_value       = mean_est;
			e.stddev_value     = stddev();
			e.count_saturated  = (tally == '1);
			e.spread_saturated = (spread_sum == '1);
			expected_stats.push_back(e);
		endfunction

		function void check_field(string name, longint unsigned want, longint unsigned got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			end
		endfunction

		function void compare_result(out_t got);
			out_t want;
			if (expected_stats.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %p", $time, got);
				return;
			end
			want = expected_stats.pop_front();
			check_field("sample_total", want.sample_total, got.sample_total);
			check_field("min_value", want.min_value, got.min_value);
			check_field("max_value", want.max_value, got.max_value);
			check_field("mean_value", want.mean_value, got.mean_value);
			check_field("stddev_value", want.stddev_value, got.stddev_value);
			check_field("count_saturated", want.count_saturated, got.count_saturated);
			check_field("spread_saturated", want.spread_saturated, got.spread_saturated);
		endfunction

		function int pending();
			return expected_stats.size();
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	in_t  req       = '0;
	logic rsp_valid;
	logic req_ready;
	logic rsp_ready = 1'b0;
	out_t rsp;

	logic calm      = 1'b0;   // stretch with no idling on either side
	int   hold_left = 0;

	stats_checker stats = new();

	running_mean_variance_stats_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Idle lengths: mostly none or short, a few long
	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic in_t make_request(logic kind, logic signed [SAMPLE_BITS-1:0] value);
		in_t r;
		r.req_type = kind;
		r.sample   = value;
		return r;
	endfunction

	// Sample mix: full range, clustered near a center, near zero, extremes
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
			logic signed [SAMPLE_BITS-1:0] center);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return $urandom;
		if (roll < 75)
			return center + $urandom_range(0, 4096) - 2048;
		if (roll < 88)
			return $urandom_range(0, 2**21) - 2**20;
		case ($urandom_range(0, 4))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return '0;
			3: return '1;
			default: return 1;
		endcase
	endfunction

	// Present one request and hold it until accepted
	task automatic send_request(input in_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		stats.take_request(r);
	endtask

	// Drop the request line and wait until every expected result is back
	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (stats.pending() != 0)
			@(posedge clk);
	endtask

	// Result side: check on handshake, stall at random
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			stats.compare_result(rsp);
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 30) begin
			hold_left <= pick_gap();
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Stimulus
	initial begin
		in_t                           directed[$];
		logic signed [SAMPLE_BITS-1:0] center;
		int                            sent;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty stats, first sample, extremes, clears, ignored payload
		directed.push_back(make_request(REQ_CLEAR, '0));
		directed.push_back(make_request(REQ_ADD, '0));
		directed.push_back(make_request(REQ_ADD, SAMPLE_MAX));
		directed.push_back(make_request(REQ_ADD, SAMPLE_MIN));
		directed.push_back(make_request(REQ_ADD, '1));
		directed.push_back(make_request(REQ_ADD, 1));
		directed.push_back(make_request(REQ_CLEAR, '1));
		directed.push_back(make_request(REQ_ADD, SAMPLE_MIN));
		directed.push_back(make_request(REQ_ADD, SAMPLE_MIN));
		directed.push_back(make_request(REQ_ADD, SAMPLE_MAX));
		directed.push_back(make_request(REQ_CLEAR, 32'h5A5A_A5A5));
		directed.push_back(make_request(REQ_ADD, SAMPLE_MAX));
		directed.push_back(make_request(REQ_ADD, SAMPLE_MIN));
		directed.push_back(make_request(REQ_ADD, 32'h0001_0000));
		directed.push_back(make_request(REQ_ADD, 32'hFFFF_0000));
		directed.push_back(make_request(REQ_CLEAR, SAMPLE_MAX));
		directed.push_back(make_request(REQ_CLEAR, SAMPLE_MIN));
		directed.push_back(make_request(REQ_ADD, 32'h1234_5678));
		directed.push_back(make_request(REQ_ADD, 32'h1234_5679));
		directed.push_back(make_request(REQ_ADD, 32'h1234_5677));
		foreach (directed[i])
			send_request(directed[i]);

		// Sender holds off until every result is back
		drain_results();

		// Random runs of samples broken up by clears
		center = $urandom;
		for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
			if (sent % 300 == 150)
				calm <= 1'b1;
			else if (sent % 300 == 200)
				calm <= 1'b0;
			if (sent == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0)
				drain_results();
			if ($urandom_range(0, 99) < 3) begin
				send_request(make_request(REQ_CLEAR, $urandom));
				center = ($urandom_range(0, 1) == 1) ? $urandom
				                                      : $urandom_range(0, 2**18) - 2**17;
			end else begin
				send_request(make_request(REQ_ADD, pick_sample(center)));
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (stats.errors == 0 && stats.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: reports an error and stops if the run of about 1520 requests hangs
	initial begin
		#40000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
